// ===== hdl/ssiu_pkg.sv =====
// shared types and constants of the sorted set insert and union unit
// no dependencies; imported by every module of the block
package ssiu_pkg;

    // data path width and default table depth
    localparam int DATA_W        = 32;
    localparam int SET_DEPTH_DEF = 16;

    // request codes
    localparam logic [1:0] REQ_INS_A = 2'd0;
    localparam logic [1:0] REQ_INS_B = 2'd1;
    localparam logic [1:0] REQ_UNION = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED    = 3'd0;
    localparam logic [2:0] ST_DUPLICATE   = 3'd1;
    localparam logic [2:0] ST_FULL        = 3'd2;
    localparam logic [2:0] ST_UNION_ELEM  = 3'd3;
    localparam logic [2:0] ST_UNION_EMPTY = 3'd4;

    // outcome of the shared signed compare
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } t_cmp_res;

endpackage

// ===== hdl/ssiu_ram.sv =====
// single write port, single read port table storage with registered read data
// depends on ssiu_pkg for the data width
module ssiu_ram
    import ssiu_pkg::*;
#(
    parameter int DEPTH = SET_DEPTH_DEF,
    parameter int AW    = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic signed [DATA_W-1:0] o_rdata
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/ssiu_cmp.sv =====
// shared signed compare used by both insert search and union merge
// depends on ssiu_pkg for the data width and the result struct
module ssiu_cmp
    import ssiu_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_x,
    input  logic signed [DATA_W-1:0] i_y,
    output t_cmp_res                 o_res
);

    // two's complement ordering of x against y
    always_comb begin
        o_res.lt = (i_x < i_y);
        o_res.eq = (i_x == i_y);
        o_res.gt = (i_x > i_y);
    end

endmodule

// ===== hdl/sorted_set_insert_union_unit.sv =====
// Sorted set insert/union unit: two ascending tables, one shared comparator, one sequencer.
// Insert: searches down from the top for the slot, then moves each entry above it up one slot;
// a duplicate or full table answers after the search alone.
// Union: a table read and a compare per result, up to 2*SET_DEPTH results; empty tables give one result.
// The result strobe is high for one cycle per result; start is taken again in the cycle of the last one.
// Synchronous active-low reset empties both tables (counts to zero); the receiver cannot stall.
module sorted_set_insert_union_unit
    import ssiu_pkg::*;
#(
    parameter int SET_DEPTH = SET_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_req_type,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic [2:0]               o_status,
    output logic                     o_last
);

    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CW = $clog2(SET_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(SET_DEPTH);
    localparam logic [CW-1:0] ONE      = CW'(1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_ISRCH  = 8'b0000_0010,
        S_ICMP   = 8'b0000_0100,
        S_IDEC   = 8'b0000_1000,
        S_ISH_RD = 8'b0001_0000,
        S_ISH_WR = 8'b0010_0000,
        S_URD    = 8'b0100_0000,
        S_UCMP   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_idx, n_idx, r_j, n_j;
    logic [CW-1:0] r_ia, n_ia, r_ib, n_ib;
    logic          r_sel, n_sel;
    logic signed [DATA_W-1:0] r_val, n_val;

    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_value, n_out_value;
    logic [2:0]               r_out_status, n_out_status;
    logic                     r_out_last, n_out_last;

    logic signed [DATA_W-1:0] rd_a, rd_b, rd_sel, cmp_x, cmp_y, wdata;
    logic [AW-1:0]            raddr_a, raddr_b, waddr;
    logic [CW-1:0]            ins_raddr, ua_raddr, ub_raddr, cnt_sel;
    logic                     we;
    t_cmp_res                 cmp;

    // table storage
    ssiu_ram #(.DEPTH(SET_DEPTH), .AW(AW)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we && !r_sel),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_a),
        .o_rdata (rd_a)
    );

    ssiu_ram #(.DEPTH(SET_DEPTH), .AW(AW)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we && r_sel),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_b),
        .o_rdata (rd_b)
    );

    // shared comparator
    ssiu_cmp u_cmp (
        .i_x   (cmp_x),
        .i_y   (cmp_y),
        .o_res (cmp)
    );

    // read address, write port and compare operand selection
    always_comb begin
        rd_sel    = r_sel ? rd_b : rd_a;
        cnt_sel   = r_sel ? r_cnt_b : r_cnt_a;
        ins_raddr = (r_state == S_ISRCH) ? (r_idx - ONE) : (r_j - ONE);
        ua_raddr  = r_ia - ONE;
        ub_raddr  = r_ib - ONE;
        if (r_state == S_URD) begin
            raddr_a = ua_raddr[AW-1:0];
            raddr_b = ub_raddr[AW-1:0];
        end else begin
            raddr_a = ins_raddr[AW-1:0];
            raddr_b = ins_raddr[AW-1:0];
        end
        if (r_state == S_UCMP) begin
            cmp_x = rd_a;
            cmp_y = rd_b;
        end else begin
            cmp_x = rd_sel;
            cmp_y = r_val;
        end
        we    = (r_state == S_ISH_WR) || ((r_state == S_ISH_RD) && (r_j == r_idx));
        waddr = (r_state == S_ISH_WR) ? r_j[AW-1:0] : r_idx[AW-1:0];
        wdata = (r_state == S_ISH_WR) ? rd_sel : r_val;
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_idx        = r_idx;
        n_j          = r_j;
        n_ia         = r_ia;
        n_ib         = r_ib;
        n_sel        = r_sel;
        n_val        = r_val;
        n_out_valid  = 1'b0;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_req_type)
                        REQ_INS_A, REQ_INS_B: begin
                            n_sel   = i_req_type[0];
                            n_val   = i_value;
                            n_idx   = i_req_type[0] ? r_cnt_b : r_cnt_a;
                            n_state = S_ISRCH;
                        end
                        REQ_UNION: begin
                            n_ia = r_cnt_a;
                            n_ib = r_cnt_b;
                            if (r_cnt_a == '0 && r_cnt_b == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_value  = '0;
                                n_out_status = ST_UNION_EMPTY;
                                n_out_last   = 1'b1;
                            end else begin
                                n_state = S_URD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // walk down from the top while entries exceed the value
            S_ISRCH: begin
                n_state = (r_idx == '0) ? S_IDEC : S_ICMP;
            end
            S_ICMP: begin
                if (cmp.gt) begin
                    n_idx   = r_idx - ONE;
                    n_state = S_ISRCH;
                end else if (cmp.eq) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_val;
                    n_out_status = ST_DUPLICATE;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_IDEC;
                end
            end
            S_IDEC: begin
                if (cnt_sel == FULL_CNT) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_val;
                    n_out_status = ST_FULL;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_j     = cnt_sel;
                    n_state = S_ISH_RD;
                end
            end
            // move entries up one slot, then drop the value into the gap
            S_ISH_RD: begin
                if (r_j == r_idx) begin
                    if (r_sel) begin
                        n_cnt_b = r_cnt_b + ONE;
                    end else begin
                        n_cnt_a = r_cnt_a + ONE;
                    end
                    n_out_valid  = 1'b1;
                    n_out_value  = r_val;
                    n_out_status = ST_INSERTED;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_ISH_WR;
                end
            end
            S_ISH_WR: begin
                n_j     = r_j - ONE;
                n_state = S_ISH_RD;
            end
            // merge from the top ends of both tables
            S_URD: begin
                n_state = S_UCMP;
            end
            S_UCMP: begin
                if (r_ia == '0) begin
                    n_out_value = rd_b;
                    n_ib        = r_ib - ONE;
                end else if (r_ib == '0) begin
                    n_out_value = rd_a;
                    n_ia        = r_ia - ONE;
                end else if (cmp.lt) begin
                    n_out_value = rd_b;
                    n_ib        = r_ib - ONE;
                end else begin
                    n_out_value = rd_a;
                    n_ia        = r_ia - ONE;
                    if (cmp.eq) begin
                        n_ib = r_ib - ONE;
                    end
                end
                n_out_valid  = 1'b1;
                n_out_status = ST_UNION_ELEM;
                n_out_last   = (n_ia == '0) && (n_ib == '0);
                n_state      = n_out_last ? S_IDLE : S_URD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_out_valid <= n_out_valid;
        end
    end

    // working and result payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_j          <= n_j;
        r_ia         <= n_ia;
        r_ib         <= n_ib;
        r_sel        <= n_sel;
        r_val        <= n_val;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_last         = r_out_last;

    // table counts stay within the depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= FULL_CNT) && (r_cnt_b <= FULL_CNT))
        else $error("table count beyond depth");

    // a final result frees the unit, a non-final one keeps it busy
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == !busy))
        else $error("last flag and busy disagree");

    // an accepted insert request always starts the search
    a_ins_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == REQ_INS_A || i_req_type == REQ_INS_B)) |=> busy)
        else $error("insert request not started");

    // an insert grows the count of exactly one of the two tables by one
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_INSERTED) |->
            (($past(r_cnt_a) + ONE == r_cnt_a) != ($past(r_cnt_b) + ONE == r_cnt_b)))
        else $error("insert count update wrong");

endmodule
